/* rtl/core/twf_pkg.sv */
// Shared constants, types and helper functions for the traveling-wave fin velocity block.
// Used by the remainder cells, the CORDIC cells and the top level. No dependencies.

package twf_pkg;

   // Fixed-point setup.
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 16;
   localparam int SH2           = 2 * FRAC_BITS;
   localparam int REG_W         = 31;
   localparam int FIELD_W       = 32;
   localparam int ANG_W         = 34;
   localparam int CSR_IDX_W     = 4;
   localparam int CIDX_W        = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_NUMBER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ANG_FREQ    = CSR_IDX_W'(1);
   localparam logic [REG_W-1:0]     WAVE_NUMBER_RST = 31'd411775;
   localparam logic [REG_W-1:0]     ANG_FREQ_RST    = 31'd411775;

   // Angle constants in Q30, and 2*pi with 2*FRAC_BITS fraction bits.
   localparam logic [63:0] TWO_PI_Q61  = 64'hC90FDAA22168C235;
   localparam logic [63:0] PH_MOD      = (TWO_PI_Q61 + (64'd1 << (60 - SH2))) >> (61 - SH2);
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic signed [ANG_W-1:0] GAIN_INV_Q30 = 34'sd652032874;

   // Remainder chain lengths: enough steps to cover the largest magnitude.
   localparam int PH_MOD_W  = $clog2(PH_MOD + 64'd1);
   localparam int PH_STEPS  = 64 - PH_MOD_W;
   localparam int TWO_PI_W  = $clog2(TWO_PI_Q30 + 64'd1);
   localparam int TH_STEPS  = 64 - FRAC_BITS - TWO_PI_W;

   // Conversion of the reduced phase to Q30.
   localparam int PH_SHR = (SH2 >= 30) ? SH2 - 30 : 0;
   localparam int PH_SHL = (SH2 < 30) ? 30 - SH2 : 0;
   localparam logic [63:0] PH_RND = (64'd1 << PH_SHR) >> 1;

   // Arctangent of 2^-i in Q30.
   localparam int ATAN_COUNT = 30;
   typedef logic [31:0] atan_tab_type [ATAN_COUNT];
   localparam atan_tab_type ATAN_Q30 = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   // A signed value split into sign and magnitude for remainder steps.
   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } mod_type;

   // CORDIC working set; neg tells that the result must be negated.
   typedef struct packed {
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    neg;
   } cord_type;

   // Per-point values that travel alongside the chains.
   typedef struct packed {
      logic                    zero;
      logic signed [31:0]      amp;
      logic signed [63:0]      ro;
      logic signed [ANG_W-1:0] c1;
   } side_type;

   // Arctangent for one CORDIC step.
   function automatic logic signed [ANG_W-1:0] atan_at(input logic [CIDX_W-1:0] idx);
      logic [4:0] i5;
      i5 = 5'(idx);
      return ANG_W'(ATAN_Q30[i5]);
   endfunction

   // Turns a truncated remainder into the non-negative remainder below div.
   function automatic logic [63:0] pos_mod(input mod_type m, input logic [63:0] div);
      logic [63:0] r;
      r = m.mag;
      if (m.neg && (m.mag != 64'd0)) begin
         r = div - m.mag;
      end
      return r;
   endfunction

   // Folds an angle in [0, 2*pi) into [-pi/2, pi/2] and seeds the rotation.
   function automatic cord_type cordic_start(input logic [63:0] a);
      cord_type c;
      c.x = GAIN_INV_Q30;
      c.y = '0;
      if (a <= HALF_PI_Q30) begin
         c.z   = ANG_W'(a);
         c.neg = 1'b0;
      end else if (a < (TWO_PI_Q30 - HALF_PI_Q30)) begin
         c.z   = ANG_W'(a - PI_Q30);
         c.neg = 1'b1;
      end else begin
         c.z   = ANG_W'(a - TWO_PI_Q30);
         c.neg = 1'b0;
      end
      return c;
   endfunction

endpackage

/* rtl/core/twf_mod_cell.sv */
// One step of a restoring remainder chain: subtracts a shifted divisor when it fits.
// Depends on twf_pkg for the mod_type and side_type structs.

module twf_mod_cell import twf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [63:0] divisor,
   input  logic        up_valid,
   input  mod_type     up_data,
   input  side_type    up_side,
   output logic        dn_valid,
   output mod_type     dn_data,
   output side_type    dn_side
);

   logic     valid_ff;
   mod_type  data_ff;
   mod_type  data_in;
   side_type side_ff;

   // Take the divisor off when the magnitude still holds it.
   always_comb begin
      data_in = up_data;
      if (up_data.mag >= divisor) begin
         data_in.mag = up_data.mag - divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
   assign dn_side  = side_ff;

endmodule

/* rtl/core/twf_cordic_cell.sv */
// One rotation-mode CORDIC step; the step number sets the shift and the arctangent.
// Depends on twf_pkg for cord_type, side_type and the arctangent table.

module twf_cordic_cell import twf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [CIDX_W-1:0] stage_idx,
   input  logic              up_valid,
   input  cord_type          up_data,
   input  side_type          up_side,
   output logic              dn_valid,
   output cord_type          dn_data,
   output side_type          dn_side
);

   logic                    valid_ff;
   cord_type                data_ff;
   cord_type                data_in;
   side_type                side_ff;
   logic signed [ANG_W-1:0] x_sh;
   logic signed [ANG_W-1:0] y_sh;
   logic signed [ANG_W-1:0] at;

   // Rotate toward zero residual angle.
   always_comb begin
      x_sh    = $signed(up_data.x) >>> stage_idx;
      y_sh    = $signed(up_data.y) >>> stage_idx;
      at      = atan_at(stage_idx);
      data_in = up_data;
      if (!up_data.z[ANG_W-1]) begin
         data_in.x = $signed(up_data.x) - y_sh;
         data_in.y = $signed(up_data.y) + x_sh;
         data_in.z = $signed(up_data.z) - at;
      end else begin
         data_in.x = $signed(up_data.x) + y_sh;
         data_in.y = $signed(up_data.y) - x_sh;
         data_in.z = $signed(up_data.z) + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
   assign dn_side  = side_ff;

endmodule

/* rtl/core/traveling_wave_fin_velocity.sv */
// Traveling-wave fin point velocity: phase, two CORDIC sine/cosine chains, saturated output.
// Depends on twf_pkg, twf_mod_cell and twf_cordic_cell.
// Throughput: one request per cycle; a stalled output holds the pipeline, and one more
// request is caught in an input skid register. Reset is synchronous and clears all
// valid flags and sets both registers to 411775 (about 2*pi).

module traveling_wave_fin_velocity import twf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // position[31:0], radius[63:32], amplitude[95:64], sim_time[127:96]
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [127:0]         req_tdata,
   // vel_y[31:0], vel_z[63:32]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   // saturated[0]
   output logic [0:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam logic signed [65:0] TH_RND  = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [67:0] RND30_W = 68'sd1 <<< 29;
   localparam logic signed [65:0] RND30_N = 66'sd1 <<< 29;
   localparam logic [99:0]        FIN_RND = 100'd1 << (SH2 - 1);

   // Configuration registers.
   logic [REG_W-1:0] wave_number_ff;
   logic [REG_W-1:0] ang_freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_number_ff <= WAVE_NUMBER_RST;
         ang_freq_ff    <= ANG_FREQ_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WAVE_NUMBER: wave_number_ff <= csr_data[REG_W-1:0];
            CSR_ANG_FREQ:    ang_freq_ff    <= csr_data[REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // The whole pipeline advances unless the output register is full and held.
   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_tready;

   // Input skid register catches one request while the pipeline is held.
   logic         skid_full_ff;
   logic         skid_full_in;
   logic [127:0] skid_data_ff;
   logic         req_acc;
   logic         in_valid_ff;
   logic         in_valid_in;
   logic [127:0] in_data_ff;

   assign req_tready  = !skid_full_ff;
   assign req_acc     = req_tvalid && req_tready;
   assign in_valid_in = skid_full_ff || req_acc;

   always_comb begin
      skid_full_in = skid_full_ff;
      if (en) begin
         skid_full_in = 1'b0;
      end else if (req_acc) begin
         skid_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_acc) begin
         skid_data_ff <= req_tdata;
      end
      if (en) begin
         in_data_ff <= skid_full_ff ? skid_data_ff : req_tdata;
      end
   end

   // Unpack the request.
   logic signed [31:0] in_x;
   logic signed [31:0] in_r;
   logic signed [31:0] in_amp;
   logic signed [31:0] in_t;
   assign in_x   = in_data_ff[31:0];
   assign in_r   = in_data_ff[63:32];
   assign in_amp = in_data_ff[95:64];
   assign in_t   = in_data_ff[127:96];

   // Products kappa*x, omega*t and r*omega.
   logic               mul_valid_ff;
   logic signed [63:0] kx_ff;
   logic signed [63:0] ot_ff;
   side_type           mul_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         kx_ff            <= 64'($signed({1'b0, wave_number_ff})) * 64'(in_x);
         ot_ff            <= 64'($signed({1'b0, ang_freq_ff})) * 64'(in_t);
         mul_side_ff.zero <= (in_t == 32'sd0);
         mul_side_ff.amp  <= in_amp;
         mul_side_ff.ro   <= 64'($signed({1'b0, ang_freq_ff})) * 64'(in_r);
         mul_side_ff.c1   <= '0;
      end
   end

   // Phase difference as sign and magnitude.
   logic     dif_valid_ff;
   mod_type  dif_data_ff;
   side_type dif_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dif_data_ff.neg <= (kx_ff < ot_ff);
         dif_data_ff.mag <= (kx_ff < ot_ff) ? 64'(ot_ff - kx_ff) : 64'(kx_ff - ot_ff);
         dif_side_ff     <= mul_side_ff;
      end
   end

   // Phase remainder chain against 2*pi.
   logic     ph_v [PH_STEPS+1];
   mod_type  ph_d [PH_STEPS+1];
   side_type ph_s [PH_STEPS+1];

   assign ph_v[0] = dif_valid_ff;
   assign ph_d[0] = dif_data_ff;
   assign ph_s[0] = dif_side_ff;

   for (genvar k = 0; k < PH_STEPS; k++) begin : g_ph
      twf_mod_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (PH_MOD << (PH_STEPS - 1 - k)),
         .up_valid (ph_v[k]),
         .up_data  (ph_d[k]),
         .up_side  (ph_s[k]),
         .dn_valid (ph_v[k+1]),
         .dn_data  (ph_d[k+1]),
         .dn_side  (ph_s[k+1])
      );
   end

   // Non-negative phase, Q30 conversion, wrap and fold.
   logic        p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [63:0] p1_ff, p2_ff, p3_ff;
   cord_type    p4_ff;
   side_type    p1_side_ff, p2_side_ff, p3_side_ff, p4_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff      <= pos_mod(ph_d[PH_STEPS], PH_MOD);
         p1_side_ff <= ph_s[PH_STEPS];
         p2_ff      <= ((p1_ff + PH_RND) >> PH_SHR) << PH_SHL;
         p2_side_ff <= p1_side_ff;
         p3_ff      <= (p2_ff >= TWO_PI_Q30) ? p2_ff - TWO_PI_Q30 : p2_ff;
         p3_side_ff <= p2_side_ff;
         p4_ff      <= cordic_start(p3_ff);
         p4_side_ff <= p3_side_ff;
      end
   end

   // First CORDIC chain: sine and cosine of the phase.
   logic     k1_v [CORDIC_STAGES+1];
   cord_type k1_d [CORDIC_STAGES+1];
   side_type k1_s [CORDIC_STAGES+1];

   assign k1_v[0] = p4_valid_ff;
   assign k1_d[0] = p4_ff;
   assign k1_s[0] = p4_side_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_k1
      twf_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_idx (CIDX_W'(k)),
         .up_valid  (k1_v[k]),
         .up_data   (k1_d[k]),
         .up_side   (k1_s[k]),
         .dn_valid  (k1_v[k+1]),
         .dn_data   (k1_d[k+1]),
         .dn_side   (k1_s[k+1])
      );
   end

   // Apply the fold sign; cos(p) joins the side values.
   logic                    s1_valid_ff;
   logic signed [ANG_W-1:0] s1_ff;
   side_type                s1_side_ff;
   side_type                s1_side_in;
   cord_type                k1_end;
   assign k1_end = k1_d[CORDIC_STAGES];

   always_comb begin
      s1_side_in    = k1_s[CORDIC_STAGES];
      s1_side_in.c1 = k1_end.neg ? -$signed(k1_end.x) : $signed(k1_end.x);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= k1_end.neg ? -$signed(k1_end.y) : $signed(k1_end.y);
         s1_side_ff <= s1_side_in;
      end
   end

   // Theta = round(A*sin(p)), then sign and magnitude.
   logic               t1_valid_ff, t2_valid_ff, t3_valid_ff;
   logic signed [65:0] t1_ff, t2_ff;
   mod_type            t3_ff;
   side_type           t1_side_ff, t2_side_ff, t3_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff      <= 66'($signed(s1_side_ff.amp)) * 66'(s1_ff);
         t1_side_ff <= s1_side_ff;
         t2_ff      <= (t1_ff + TH_RND) >>> FRAC_BITS;
         t2_side_ff <= t1_side_ff;
         t3_ff.neg  <= t2_ff[65];
         t3_ff.mag  <= t2_ff[65] ? 64'(-t2_ff) : 64'(t2_ff);
         t3_side_ff <= t2_side_ff;
      end
   end

   // Theta remainder chain against 2*pi in Q30.
   logic     th_v [TH_STEPS+1];
   mod_type  th_d [TH_STEPS+1];
   side_type th_s [TH_STEPS+1];

   assign th_v[0] = t3_valid_ff;
   assign th_d[0] = t3_ff;
   assign th_s[0] = t3_side_ff;

   for (genvar k = 0; k < TH_STEPS; k++) begin : g_th
      twf_mod_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .divisor  (TWO_PI_Q30 << (TH_STEPS - 1 - k)),
         .up_valid (th_v[k]),
         .up_data  (th_d[k]),
         .up_side  (th_s[k]),
         .dn_valid (th_v[k+1]),
         .dn_data  (th_d[k+1]),
         .dn_side  (th_s[k+1])
      );
   end

   // Non-negative theta and fold.
   logic        q1_valid_ff, q2_valid_ff;
   logic [63:0] q1_ff;
   cord_type    q2_ff;
   side_type    q1_side_ff, q2_side_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff      <= pos_mod(th_d[TH_STEPS], TWO_PI_Q30);
         q1_side_ff <= th_s[TH_STEPS];
         q2_ff      <= cordic_start(q1_ff);
         q2_side_ff <= q1_side_ff;
      end
   end

   // Second CORDIC chain: sine and cosine of theta.
   logic     k2_v [CORDIC_STAGES+1];
   cord_type k2_d [CORDIC_STAGES+1];
   side_type k2_s [CORDIC_STAGES+1];

   assign k2_v[0] = q2_valid_ff;
   assign k2_d[0] = q2_ff;
   assign k2_s[0] = q2_side_ff;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_k2
      twf_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_idx (CIDX_W'(k)),
         .up_valid  (k2_v[k]),
         .up_data   (k2_d[k]),
         .up_side   (k2_s[k]),
         .dn_valid  (k2_v[k+1]),
         .dn_data   (k2_d[k+1]),
         .dn_side   (k2_s[k+1])
      );
   end

   // Index 0 is the y velocity path (cos theta), index 1 the z path (sin theta).
   logic                    u1_valid_ff, u2_valid_ff, u3_valid_ff, u4_valid_ff, u5_valid_ff;
   logic signed [ANG_W-1:0] u1_ff [2];
   logic signed [67:0]      u2_ff [2];
   logic signed [ANG_W-1:0] u3_ff [2];
   logic signed [65:0]      u4_ff [2];
   logic signed [ANG_W-1:0] u5_ff [2];
   side_type                u1_side_ff, u2_side_ff, u3_side_ff, u4_side_ff, u5_side_ff;
   cord_type                k2_end;
   assign k2_end = k2_d[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff[0]   <= k2_end.neg ? -$signed(k2_end.x) : $signed(k2_end.x);
         u1_ff[1]   <= k2_end.neg ? -$signed(k2_end.y) : $signed(k2_end.y);
         u1_side_ff <= k2_s[CORDIC_STAGES];
         u2_side_ff <= u1_side_ff;
         u3_side_ff <= u2_side_ff;
         u4_side_ff <= u3_side_ff;
         u5_side_ff <= u4_side_ff;
         for (int i = 0; i < 2; i++) begin
            u2_ff[i] <= 68'($signed(u1_side_ff.c1)) * 68'(u1_ff[i]);
            u3_ff[i] <= ANG_W'((u2_ff[i] + RND30_W) >>> 30);
            u4_ff[i] <= 66'($signed(u3_side_ff.amp)) * 66'(u3_ff[i]);
            u5_ff[i] <= ANG_W'((u4_ff[i] + RND30_N) >>> 30);
         end
      end
   end

   // Final product r*omega*aw in partial products, rounding and saturation.
   logic               f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic [63:0]        f1_ma_ff;
   logic [ANG_W-1:0]   f1_mb_ff [2];
   logic [65:0]        f2_lo_ff [2];
   logic [65:0]        f2_hi_ff [2];
   logic [99:0]        f3_ff [2];
   logic [99:0]        f4_full [2];
   logic [31:0]        f4_limit [2];
   logic [31:0]        f4_ff [2];
   logic               f4_sat_ff [2];
   logic               out_neg_ff [4][2];
   logic               zero_ff [4];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         f4_full[i]  = f3_ff[i] >> SH2;
         f4_limit[i] = out_neg_ff[2][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ma_ff   <= u5_side_ff.ro[63] ? 64'(-u5_side_ff.ro) : 64'(u5_side_ff.ro);
         zero_ff[0] <= u5_side_ff.zero;
         for (int j = 1; j < 4; j++) begin
            zero_ff[j] <= zero_ff[j-1];
         end
         for (int i = 0; i < 2; i++) begin
            f1_mb_ff[i]      <= u5_ff[i][ANG_W-1] ? ANG_W'(-u5_ff[i]) : ANG_W'(u5_ff[i]);
            out_neg_ff[0][i] <= (u5_side_ff.ro[63] == u5_ff[i][ANG_W-1]);
            for (int j = 1; j < 4; j++) begin
               out_neg_ff[j][i] <= out_neg_ff[j-1][i];
            end
            f2_lo_ff[i]  <= 66'(f1_ma_ff[31:0]) * 66'(f1_mb_ff[i]);
            f2_hi_ff[i]  <= 66'(f1_ma_ff[63:32]) * 66'(f1_mb_ff[i]);
            f3_ff[i]     <= 100'(f2_lo_ff[i]) + (100'(f2_hi_ff[i]) << 32) + FIN_RND;
            f4_sat_ff[i] <= (f4_full[i] > 100'(f4_limit[i]));
            f4_ff[i]     <= (f4_full[i] > 100'(f4_limit[i])) ? f4_limit[i] : f4_full[i][31:0];
         end
      end
   end

   // Output register: sign, saturation flag and the time-zero case.
   logic [31:0] rsp_vy_ff;
   logic [31:0] rsp_vz_ff;
   logic        rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[3]) begin
            rsp_vy_ff  <= '0;
            rsp_vz_ff  <= '0;
            rsp_sat_ff <= 1'b0;
         end else begin
            rsp_vy_ff  <= out_neg_ff[3][0] ? -f4_ff[0] : f4_ff[0];
            rsp_vz_ff  <= out_neg_ff[3][1] ? -f4_ff[1] : f4_ff[1];
            rsp_sat_ff <= f4_sat_ff[0] || f4_sat_ff[1];
         end
      end
   end

   // Valid flags of the stages outside the cell chains.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         dif_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         t3_valid_ff  <= 1'b0;
         q1_valid_ff  <= 1'b0;
         q2_valid_ff  <= 1'b0;
         u1_valid_ff  <= 1'b0;
         u2_valid_ff  <= 1'b0;
         u3_valid_ff  <= 1'b0;
         u4_valid_ff  <= 1'b0;
         u5_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         f4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
         if (en) begin
            in_valid_ff  <= in_valid_in;
            mul_valid_ff <= in_valid_ff;
            dif_valid_ff <= mul_valid_ff;
            p1_valid_ff  <= ph_v[PH_STEPS];
            p2_valid_ff  <= p1_valid_ff;
            p3_valid_ff  <= p2_valid_ff;
            p4_valid_ff  <= p3_valid_ff;
            s1_valid_ff  <= k1_v[CORDIC_STAGES];
            t1_valid_ff  <= s1_valid_ff;
            t2_valid_ff  <= t1_valid_ff;
            t3_valid_ff  <= t2_valid_ff;
            q1_valid_ff  <= th_v[TH_STEPS];
            q2_valid_ff  <= q1_valid_ff;
            u1_valid_ff  <= k2_v[CORDIC_STAGES];
            u2_valid_ff  <= u1_valid_ff;
            u3_valid_ff  <= u2_valid_ff;
            u4_valid_ff  <= u3_valid_ff;
            u5_valid_ff  <= u4_valid_ff;
            f1_valid_ff  <= u5_valid_ff;
            f2_valid_ff  <= f1_valid_ff;
            f3_valid_ff  <= f2_valid_ff;
            f4_valid_ff  <= f3_valid_ff;
            rsp_valid_ff <= f4_valid_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_vz_ff, rsp_vy_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

/* tb/tb.sv */
// Self-checking testbench for traveling_wave_fin_velocity: streams fin points through the
// block under several wave settings and checks every velocity against a local predictor.
// Depends on twf_pkg and the traveling_wave_fin_velocity RTL.
`timescale 1ns / 1ps

module tb;
   import twf_pkg::*;

   typedef struct {
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic        sat;
   } velocity_type;

   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE_CYC  = 140;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [127:0]         req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   logic [127:0]  point_queue[$];
   velocity_type  velocity_queue[$];
   logic [30:0]   kappa_q = 31'd411775;
   logic [30:0]   omega_q = 31'd411775;
   int            fail_count = 0;
   int            idle_cycles = 0;

   traveling_wave_fin_velocity i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Rounded arithmetic shift: floor(v + half).
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Sine and cosine of a Q30 angle through a folded rotation-mode CORDIC.
   function automatic void trig_q30(input longint a, output longint s, output longint c);
      longint r, x, y, nx, at;
      bit     flip;
      r    = a % longint'(TWO_PI_Q30);
      x    = 64'sd652032874;
      y    = 0;
      flip = 1'b0;
      if (r < 0) r += longint'(TWO_PI_Q30);
      if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
      if (r > longint'(HALF_PI_Q30)) begin
         r -= longint'(PI_Q30);
         flip = 1'b1;
      end else if (r < -longint'(HALF_PI_Q30)) begin
         r += longint'(PI_Q30);
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
         at = longint'(ATAN_Q30[i]);
         if (r >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            r -= at;
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            r += at;
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   // -round(ro*aw / 2^32) with half away from zero, clamped to 32 bits.
   function automatic logic [31:0] clamp_velocity(input longint ro, input longint aw,
                                                  inout bit sat);
      logic [127:0] ma, mb, prod;
      logic [63:0]  m, limit;
      bit           neg;
      ma    = {64'd0, 64'(ro < 0 ? -ro : ro)};
      mb    = {64'd0, 64'(aw < 0 ? -aw : aw)};
      prod  = ma * mb + (128'd1 << 31);
      neg   = ((ro < 0) == (aw < 0));
      limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (prod[127:96] != '0) begin
         m   = limit;
         sat = 1'b1;
      end else begin
         m = prod[95:32];
         if (m > limit) begin
            m   = limit;
            sat = 1'b1;
         end
      end
      return neg ? 32'(-m) : 32'(m);
   endfunction

   // Fin point velocity for one request under the current wave settings.
   function automatic velocity_type fin_velocity(input logic [127:0] d);
      velocity_type v;
      longint x, r, amp, t, kap, om, mod2f, ph, p30, s1, c1, th, s2, c2, ro;
      bit     sat;
      x   = longint'($signed(d[31:0]));
      r   = longint'($signed(d[63:32]));
      amp = longint'($signed(d[95:64]));
      t   = longint'($signed(d[127:96]));
      kap = longint'({1'b0, kappa_q});
      om  = longint'({1'b0, omega_q});
      sat = 1'b0;
      v   = '{32'd0, 32'd0, 1'b0};
      if (t == 0) return v;
      mod2f = longint'((64'hC90FDAA22168C235 + (64'd1 << 28)) >> 29);
      ph    = kap * x - om * t;
      ph    = ph % mod2f;
      if (ph < 0) ph += mod2f;
      p30 = round_shift(ph, 2);
      trig_q30(p30, s1, c1);
      th = round_shift(amp * s1, 16);
      trig_q30(th, s2, c2);
      ro      = r * om;
      v.vel_y = clamp_velocity(ro, round_shift(amp * round_shift(c1 * c2, 30), 30), sat);
      v.vel_z = clamp_velocity(ro, round_shift(amp * round_shift(c1 * s2, 30), 30), sat);
      v.sat   = sat;
      return v;
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         if (req_tvalid && req_tready) velocity_queue.push_back(fin_velocity(req_tdata));
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (point_queue.size() > 0) begin
               req_tdata <= point_queue.pop_front();
               next_valid = 1'b1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
         req_tvalid <= next_valid;
      end
   end

   // Response monitor with its own stall pattern: free-running, random or mostly stalled.
   int stall_mode = 0;
   int mode_left  = 0;
   always @(posedge clock) begin
      velocity_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (velocity_queue.size() == 0) begin
               $error("unexpected response vel_y=%h vel_z=%h", rsp_tdata[31:0],
                      rsp_tdata[63:32]);
               fail_count++;
            end else begin
               exp_v = velocity_queue.pop_front();
               if (rsp_tdata[31:0] !== exp_v.vel_y) begin
                  $error("vel_y expected %h actual %h", exp_v.vel_y, rsp_tdata[31:0]);
                  fail_count++;
               end
               if (rsp_tdata[63:32] !== exp_v.vel_z) begin
                  $error("vel_z expected %h actual %h", exp_v.vel_z, rsp_tdata[63:32]);
                  fail_count++;
               end
               if (rsp_tuser[0] !== exp_v.sat) begin
                  $error("saturated expected %b actual %b", exp_v.sat, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(30, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog on cycles in which no request, response or register write is accepted.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("traveling_wave_fin_velocity regression: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_WAVE_NUMBER) kappa_q = value[30:0];
      else if (idx == CSR_ANG_FREQ) omega_q = value[30:0];
   endtask

   // Waits until every request has gone through and the pipeline has drained.
   task automatic drain();
      do @(posedge clock);
      while (point_queue.size() != 0 || req_tvalid || velocity_queue.size() != 0);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   function automatic logic [127:0] pack_point(input logic [31:0] x, input logic [31:0] r,
                                               input logic [31:0] a, input logic [31:0] t);
      return {t, a, r, x};
   endfunction

   // Mostly physical fin points, some with full-range noise in every field.
   task automatic add_random(input int count);
      logic [31:0] x, r, a, t;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            x = $urandom(); r = $urandom(); a = $urandom(); t = $urandom();
         end else begin
            x = 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
            r = 32'($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
            a = 32'($signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000);
            t = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 32'h80_0000);
         end
         point_queue.push_back(pack_point(x, r, a, t));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset settings.
      point_queue.push_back(pack_point(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'd0));
      point_queue.push_back(pack_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
      point_queue.push_back(pack_point(32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000));
      point_queue.push_back(pack_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd1));
      point_queue.push_back(pack_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000));
      point_queue.push_back(pack_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF));
      point_queue.push_back(pack_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'hFFFF_FFFF));
      point_queue.push_back(pack_point(32'h0, 32'h0, 32'h0, 32'h0001_0000));
      point_queue.push_back(pack_point(32'h0, 32'h7FFF_FFFF, 32'h0010_0000, 32'h0000_3000));
      point_queue.push_back(pack_point(32'h0, 32'h8000_0000, 32'h0010_0000, 32'h0000_3000));
      point_queue.push_back(pack_point(32'h0003_0000, 32'h0100_0000, 32'h4000_0000,
                                       32'h0002_0000));
      point_queue.push_back(pack_point(32'hFFFD_0000, 32'h0000_8000, 32'hC000_0000,
                                       32'hFFFE_0000));
      point_queue.push_back(pack_point(32'h0000_4000, 32'h0001_0000, 32'h0000_8000,
                                       32'h8000_0000));
      point_queue.push_back(pack_point(32'h8000_0000, 32'h0001_0000, 32'h0000_8000,
                                       32'h7FFF_FFFF));
      point_queue.push_back(pack_point(32'h1234_5678, 32'hEDCB_A988, 32'h0002_0000,
                                       32'h0000_0001));
      point_queue.push_back(pack_point(32'h0000_C000, 32'h0000_4000, 32'h0000_4000,
                                       32'hFFFF_FFFF));
      add_random(170);
      drain();

      // Zero wave settings; an out-of-range index must leave the registers alone.
      write_reg(CSR_WAVE_NUMBER, 32'h8000_0000);
      write_reg(CSR_ANG_FREQ, 32'h0);
      write_reg(CSR_IDX_W'(5), 32'h1234_5678);
      write_reg(CSR_IDX_W'(15), 32'hFFFF_FFFF);
      add_random(165);
      drain();

      // Largest settings drive the saturation path hard.
      write_reg(CSR_WAVE_NUMBER, 32'h7FFF_FFFF);
      write_reg(CSR_ANG_FREQ, 32'hFFFF_FFFF);
      add_random(165);
      drain();

      // Random settings.
      write_reg(CSR_WAVE_NUMBER, $urandom());
      write_reg(CSR_ANG_FREQ, $urandom());
      add_random(165);
      drain();

      // Slow wave in space, fast in time.
      write_reg(CSR_WAVE_NUMBER, $urandom_range(1, 32'h1_0000));
      write_reg(CSR_ANG_FREQ, $urandom_range(32'h10_0000, 32'h100_0000));
      add_random(165);
      drain();

      if (fail_count == 0) begin
         $display("traveling_wave_fin_velocity regression: pass");
      end else begin
         $display("traveling_wave_fin_velocity regression: fail");
      end
      $finish;
   end

endmodule
